>>> hw/rtl/lcgsc_pkg.sv
// ----------------------------------------------------------------------------
// lcgsc_pkg
// Shared widths, register indexes and structs of the LCG keystream byte cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgsc_pkg;

	localparam int DATA_W    = 8;
	localparam int TERM_W    = 31;
	localparam int KEY_LEN_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = $clog2(TERM_W);

	localparam int MAX_KEY_TERMS = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT    = 3'd5;

	// Settings as the datapath uses them: modulus at least one, length clamped.
	typedef struct packed {
		logic [TERM_W-1:0]    modulus;
		logic [TERM_W-1:0]    multiplier;
		logic [TERM_W-1:0]    increment;
		logic [TERM_W-1:0]    seed;
		logic [KEY_LEN_W-1:0] key_len;
		logic                 decrypt;
	} cfg_t;

	typedef struct packed {
		logic              start_reduce;
		logic              start_mul;
		logic [TERM_W-1:0] operand;
	} mod_cmd_t;

	typedef struct packed {
		logic              done;
		logic [TERM_W-1:0] residue;
	} mod_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/lcgsc_if.sv
// ----------------------------------------------------------------------------
// lcgsc_if
// Valid/ready channels for the input bytes and the result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcgsc_in_if import lcgsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              restart;

	modport source (output valid, data_byte, restart, input ready);
	modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface lcgsc_out_if import lcgsc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result_byte;

	modport source (output valid, result_byte, input ready);
	modport sink   (input valid, result_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lcg_gamma_stream_cipher.sv
// ----------------------------------------------------------------------------
// lcg_gamma_stream_cipher
// Byte stream cipher that adds or subtracts the low byte of an LCG key term.
// ----------------------------------------------------------------------------
// Usage: bytes enter on data_in (valid/ready, with a restart flag marking the
// first byte of a message) and each yields exactly one byte on data_out.
// Settings are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while no item is in flight, as the block does not enforce
// it. data_in accepts one item at a time. After acceptance the key term is
// reduced modulo m one bit per cycle, and once the reduction is done the
// result is loaded into the output register. Unless the item was the last
// term of the key, the next term (a*x + c) mod m is then formed by Horner
// steps over the multiplier bits, each a doubling step and an add step, and
// data_in is ready for the next item only once that term is stored (at the
// end of the key, once the result is loaded). Reset restores modulus 1, key
// length 1, all other settings zero, and restarts the keystream at the seed.
// A stalled receiver holds the result in the output register. The next item
// is still accepted and reduced, but its result is loaded and its next term
// started only once that register is free again.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_gamma_stream_cipher import lcgsc_pkg::*; #(
	parameter int MAX_TERMS = MAX_KEY_TERMS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	lcgsc_in_if.sink                  data_in,
	lcgsc_out_if.source               data_out,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TERM_W-1:0]    cfg_wdata
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REDUCE = 2'd1;
	localparam logic [1:0] ST_EMIT   = 2'd2;
	localparam logic [1:0] ST_NEXT   = 2'd3;

	cfg_t      cfg;
	mod_cmd_t  cmd;
	mod_stat_t stat;

	logic [1:0]           state_q;
	logic [KEY_LEN_W-1:0] pos_q;
	logic [TERM_W-1:0]    cur_q;
	logic [DATA_W-1:0]    data_q;
	logic                 out_valid_q;
	logic [DATA_W-1:0]    result_q;

	logic                 accept;
	logic                 from_seed;
	logic                 slot_free;
	logic                 last_term;
	logic [DATA_W-1:0]    key_byte;
	logic [DATA_W-1:0]    combined;

	lcgsc_cfg #(
		.MAX_TERMS (MAX_TERMS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lcgsc_modunit u_modunit (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign data_in.ready = (state_q == ST_IDLE);
	assign accept        = data_in.valid && data_in.ready;

	// Position zero, a restart or a position past a shortened key all mean x0.
	assign from_seed = data_in.restart || (pos_q == '0) || (pos_q >= cfg.key_len);
	assign slot_free = !out_valid_q || data_out.ready;
	assign last_term = ({1'b0, pos_q} + (KEY_LEN_W+1)'(1)) >= {1'b0, cfg.key_len};

	assign key_byte = stat.residue[DATA_W-1:0];
	assign combined = cfg.decrypt ? (data_q - key_byte) : (data_q + key_byte);

	always_comb begin
		cmd.start_reduce = accept;
		cmd.start_mul    = (state_q == ST_EMIT) && slot_free && !last_term;
		cmd.operand      = from_seed ? cfg.seed : cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && data_out.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (from_seed)
							pos_q <= '0;
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (stat.done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (last_term) begin
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q + KEY_LEN_W'(1);
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					if (stat.done) begin
						cur_q   <= stat.residue;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			data_q <= data_in.data_byte;
		if ((state_q == ST_EMIT) && slot_free)
			result_q <= combined;
	end

	assign data_out.valid       = out_valid_q;
	assign data_out.result_byte = result_q;

endmodule

`default_nettype wire

>>> hw/rtl/lcgsc_cfg.sv
// ----------------------------------------------------------------------------
// lcgsc_cfg
// Configuration registers; decodes writes and stores sanitized settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsc_cfg import lcgsc_pkg::*; #(
	parameter int MAX_TERMS = MAX_KEY_TERMS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TERM_W-1:0]    cfg_wdata,
	output cfg_t                      cfg
);

	localparam int MAX_LEN_INT = (MAX_TERMS < (1 << KEY_LEN_W)) ?
		MAX_TERMS : (1 << KEY_LEN_W) - 1;
	localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_LEN_INT);

	logic [TERM_W-1:0]    modulus_q;
	logic [TERM_W-1:0]    multiplier_q;
	logic [TERM_W-1:0]    increment_q;
	logic [TERM_W-1:0]    seed_q;
	logic [KEY_LEN_W-1:0] key_len_q;
	logic                 decrypt_q;
	logic [KEY_LEN_W-1:0] wlen;

	assign wlen = cfg_wdata[KEY_LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q    <= TERM_W'(1);
			multiplier_q <= '0;
			increment_q  <= '0;
			seed_q       <= '0;
			key_len_q    <= KEY_LEN_W'(1);
			decrypt_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODULUS: begin
					// A zero modulus behaves as a modulus of one.
					modulus_q <= (cfg_wdata == '0) ? TERM_W'(1) : cfg_wdata;
				end
				REG_MULTIPLIER: multiplier_q <= cfg_wdata;
				REG_INCREMENT:  increment_q  <= cfg_wdata;
				REG_SEED:       seed_q       <= cfg_wdata;
				REG_KEY_LENGTH: begin
					if (wlen == '0)
						key_len_q <= KEY_LEN_W'(1);
					else if (wlen > MAX_LEN)
						key_len_q <= MAX_LEN;
					else
						key_len_q <= wlen;
				end
				REG_DECRYPT:    decrypt_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg.modulus    = modulus_q;
	assign cfg.multiplier = multiplier_q;
	assign cfg.increment  = increment_q;
	assign cfg.seed       = seed_q;
	assign cfg.key_len    = key_len_q;
	assign cfg.decrypt    = decrypt_q;

endmodule

`default_nettype wire

>>> hw/rtl/lcgsc_modunit.sv
// ----------------------------------------------------------------------------
// lcgsc_modunit
// Bit-serial residue engine: x mod m, and (a * term + c) mod m by Horner steps.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgsc_modunit import lcgsc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  mod_cmd_t  cmd,
	output mod_stat_t stat
);

	localparam logic [1:0] MS_IDLE   = 2'd0;
	localparam logic [1:0] MS_REDUCE = 2'd1;
	localparam logic [1:0] MS_DBL    = 2'd2;
	localparam logic [1:0] MS_ADD    = 2'd3;

	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(TERM_W - 1);

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [TERM_W-1:0] r_q;
	logic [TERM_W-1:0] b_sh_q;
	logic [TERM_W-1:0] a_sh_q;
	logic [TERM_W-1:0] term_q;
	logic [TERM_W-1:0] d_q;

	logic [TERM_W:0]   dbl;
	logic [TERM_W+1:0] dbl_diff;
	logic [TERM_W-1:0] dbl_res;
	logic [TERM_W:0]   add_sum;
	logic [TERM_W:0]   add_diff;
	logic [TERM_W-1:0] add_res;

	// Doubling step: r = (2r + next bit) mod m; the sum stays below 2m.
	always_comb begin
		dbl      = {r_q, b_sh_q[TERM_W-1]};
		dbl_diff = {1'b0, dbl} - {2'b00, cfg.modulus};
		dbl_res  = dbl_diff[TERM_W+1] ? dbl[TERM_W-1:0] : dbl_diff[TERM_W-1:0];
	end

	// Add step: r = (r + term) mod m, with d = m - term precomputed.
	always_comb begin
		add_sum  = {1'b0, r_q} + {1'b0, term_q};
		add_diff = {1'b0, r_q} - {1'b0, d_q};
		add_res  = add_diff[TERM_W] ? add_sum[TERM_W-1:0] : add_diff[TERM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MS_IDLE: begin
					if (cmd.start_reduce) begin
						state_q <= MS_REDUCE;
						cnt_q   <= LAST_BIT;
					end else if (cmd.start_mul) begin
						state_q <= MS_DBL;
						cnt_q   <= LAST_BIT;
					end
				end
				MS_REDUCE: begin
					if (cnt_q == '0) begin
						state_q <= MS_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				MS_DBL: state_q <= MS_ADD;
				MS_ADD: begin
					if (cnt_q == '0) begin
						state_q <= MS_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= MS_DBL;
					end
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				if (cmd.start_reduce) begin
					r_q    <= '0;
					b_sh_q <= cmd.operand;
				end else if (cmd.start_mul) begin
					// The residue held now is the reduced term of this item.
					term_q <= r_q;
					d_q    <= cfg.modulus - r_q;
					r_q    <= '0;
					a_sh_q <= cfg.multiplier;
					b_sh_q <= cfg.increment;
				end
			end
			MS_REDUCE, MS_DBL: begin
				r_q    <= dbl_res;
				b_sh_q <= {b_sh_q[TERM_W-2:0], 1'b0};
			end
			MS_ADD: begin
				if (a_sh_q[TERM_W-1])
					r_q <= add_res;
				a_sh_q <= {a_sh_q[TERM_W-2:0], 1'b0};
			end
			default: ;
		endcase
	end

	assign stat.done    = done_q;
	assign stat.residue = r_q;

endmodule

`default_nettype wire
